// File: rtl/core/clca_pkg.sv
// ---------------------------------------------------------------------------
// clca_pkg
// shared types and constants of the cluster chain allocator
// ---------------------------------------------------------------------------
package clca_pkg;

  // default table size
  localparam int unsigned NUM_CLUSTERS_DEF = 4096;

  // field widths of one item, table entry and result
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned CLUSTER_W = 12;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FORMAT = 3'd0,
    ACT_ALLOC  = 3'd1,
    ACT_EXTEND = 3'd2,
    ACT_READ   = 3'd3,
    ACT_FREE   = 3'd4
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FREE = 2'd0,
    KIND_LINK = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_SHORT  = 2'd1,
    STATUS_BROKEN = 2'd2
  } status_e;

  typedef struct packed {
    logic [CLUSTER_W-1:0] first_cluster;
    kind_e                entry_kind;
    logic [CLUSTER_W-1:0] entry_target;
    status_e              status;
  } result_t;

endpackage

// File: rtl/core/clca_table.sv
// ---------------------------------------------------------------------------
// clca_table
// link table memory: one write port, one read port with registered data
// ---------------------------------------------------------------------------
module clca_table #(
  parameter int unsigned NUM_CLUSTERS = clca_pkg::NUM_CLUSTERS_DEF,
  localparam int unsigned IDX_W = $clog2(NUM_CLUSTERS),
  localparam int unsigned ENT_W = IDX_W + clca_pkg::KIND_W
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [ENT_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [ENT_W-1:0] wr_data_i
);

  logic [ENT_W-1:0] mem_q [NUM_CLUSTERS];
  logic [ENT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/clca_seq.sv
// ---------------------------------------------------------------------------
// clca_seq
// sequencer: clearing sweep, chain walk and the shared free-entry scanner
// ---------------------------------------------------------------------------
module clca_seq #(
  parameter int unsigned NUM_CLUSTERS = clca_pkg::NUM_CLUSTERS_DEF,
  localparam int unsigned IDX_W = $clog2(NUM_CLUSTERS),
  localparam int unsigned PTR_W = IDX_W + 1,
  localparam int unsigned ENT_W = IDX_W + clca_pkg::KIND_W
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item side
  input  logic                               in_valid_i,
  output logic                               in_busy_o,
  input  logic [clca_pkg::ACTION_W-1:0]      action_i,
  input  logic [clca_pkg::CLUSTER_W-1:0]     cluster_i,
  input  logic [clca_pkg::COUNT_W-1:0]       count_i,
  // result side
  output logic                               res_valid_o,
  input  logic                               res_stall_i,
  output clca_pkg::result_t                  res_o,
  // table port
  output logic                               mem_rd_en_o,
  output logic [IDX_W-1:0]                   mem_rd_addr_o,
  input  logic [ENT_W-1:0]                   mem_rd_data_i,
  output logic                               mem_wr_en_o,
  output logic [IDX_W-1:0]                   mem_wr_addr_o,
  output logic [ENT_W-1:0]                   mem_wr_data_o
);

  localparam logic [PTR_W-1:0] N_P    = PTR_W'(NUM_CLUSTERS);
  localparam logic [PTR_W-1:0] LAST_P = PTR_W'(NUM_CLUSTERS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_SCAN,
    ST_FINAL,
    ST_READ_CHK,
    ST_DONE
  } state_e;

  // control
  state_e                            state_q, state_d;
  logic [PTR_W-1:0]                  ptr_q, ptr_d;
  logic                              report_q, report_d;
  logic                              pend_q, pend_d;
  logic                              chain_q, chain_d;
  logic                              has_prev_q, has_prev_d;
  logic [clca_pkg::COUNT_W-1:0]      n_q, n_d;
  logic [PTR_W-1:0]                  steps_q, steps_d;
  clca_pkg::result_t                 res_q, res_d;

  // payload
  logic [clca_pkg::ACTION_W-1:0]     act_q, act_d;
  logic [clca_pkg::CLUSTER_W-1:0]    cl_q, cl_d;
  logic [clca_pkg::COUNT_W-1:0]      cnt_q, cnt_d;
  logic [clca_pkg::COUNT_W-1:0]      need_q, need_d;
  logic [PTR_W-1:0]                  base_q, base_d;
  logic [IDX_W-1:0]                  cur_q, cur_d;
  logic [IDX_W-1:0]                  prev_q, prev_d;
  logic [IDX_W-1:0]                  paddr_q, paddr_d;
  logic [IDX_W-1:0]                  first_q, first_d;

  clca_pkg::kind_e                   rd_kind;
  logic [IDX_W-1:0]                  rd_tgt;
  logic                              cl_in_range;
  logic                              hit;
  logic                              last_hit;
  logic [clca_pkg::COUNT_W-1:0]      n_inc;

  assign rd_kind     = clca_pkg::kind_e'(mem_rd_data_i[ENT_W-1 -: clca_pkg::KIND_W]);
  assign rd_tgt      = mem_rd_data_i[IDX_W-1:0];
  assign cl_in_range = (32'(cl_q) < 32'(NUM_CLUSTERS));
  assign n_inc       = n_q + 1'b1;
  assign hit         = pend_q && (rd_kind == clca_pkg::KIND_FREE);
  assign last_hit    = hit && (n_inc == need_q);

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    report_d   = report_q;
    pend_d     = pend_q;
    chain_d    = chain_q;
    has_prev_d = has_prev_q;
    n_d        = n_q;
    steps_d    = steps_q;
    res_d      = res_q;
    act_d      = act_q;
    cl_d       = cl_q;
    cnt_d      = cnt_q;
    need_d     = need_q;
    base_d     = base_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    paddr_d    = paddr_q;
    first_d    = first_q;

    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = cur_q;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = prev_q;
    mem_wr_data_o = '0;
    res_valid_o   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = ptr_q[IDX_W-1:0];
        mem_wr_data_o = {clca_pkg::KIND_FREE, {IDX_W{1'b0}}};
        ptr_d         = ptr_q + 1'b1;
        if (ptr_q == LAST_P) begin
          report_d = 1'b0;
          state_d  = report_q ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          cl_d    = cluster_i;
          cnt_d   = count_i;
          state_d = ST_START;
        end
      end

      ST_START: begin
        res_d   = '0;
        cur_d   = IDX_W'(cl_q);
        state_d = ST_DONE;
        unique case (clca_pkg::action_e'(act_q))
          clca_pkg::ACT_FORMAT: begin
            ptr_d    = '0;
            report_d = 1'b1;
            state_d  = ST_CLEAR;
          end
          clca_pkg::ACT_ALLOC: begin
            need_d     = (cnt_q == '0) ? clca_pkg::COUNT_W'(1) : cnt_q;
            base_d     = '0;
            ptr_d      = '0;
            n_d        = '0;
            pend_d     = 1'b0;
            chain_d    = 1'b0;
            has_prev_d = 1'b0;
            state_d    = ST_SCAN;
          end
          clca_pkg::ACT_EXTEND: begin
            steps_d = '0;
            if (cl_in_range) begin
              state_d = ST_WALK_RD;
            end else begin
              res_d.status = clca_pkg::STATUS_BROKEN;
            end
          end
          clca_pkg::ACT_READ: begin
            if (cl_in_range) begin
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = IDX_W'(cl_q);
              state_d       = ST_READ_CHK;
            end
          end
          clca_pkg::ACT_FREE: begin
            if (cl_in_range) begin
              mem_wr_en_o   = 1'b1;
              mem_wr_addr_o = IDX_W'(cl_q);
              mem_wr_data_o = {clca_pkg::KIND_FREE, {IDX_W{1'b0}}};
            end
          end
          default: begin
          end
        endcase
      end

      ST_WALK_RD: begin
        mem_rd_en_o   = 1'b1;
        mem_rd_addr_o = cur_q;
        state_d       = ST_WALK_CHK;
      end

      ST_WALK_CHK: begin
        if (rd_kind == clca_pkg::KIND_END) begin
          if (cnt_q == '0) begin
            state_d = ST_DONE;
          end else begin
            // tail found: scan above it, old tail is the first link source
            need_d     = cnt_q;
            base_d     = {1'b0, cur_q} + 1'b1;
            ptr_d      = {1'b0, cur_q} + 1'b1;
            n_d        = '0;
            pend_d     = 1'b0;
            chain_d    = 1'b0;
            has_prev_d = 1'b1;
            prev_d     = cur_q;
            state_d    = ST_SCAN;
          end
        end else if ((rd_kind == clca_pkg::KIND_LINK) && ({1'b0, rd_tgt} < N_P)
                     && (steps_q < N_P)) begin
          cur_d   = rd_tgt;
          steps_d = steps_q + 1'b1;
          state_d = ST_WALK_RD;
        end else begin
          res_d.status = clca_pkg::STATUS_BROKEN;
          state_d      = ST_DONE;
        end
      end

      ST_SCAN: begin
        // read one entry per cycle, judge the entry read in the cycle before
        if ((ptr_q < N_P) && !last_hit) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = ptr_q[IDX_W-1:0];
          ptr_d         = ptr_q + 1'b1;
          pend_d        = 1'b1;
          paddr_d       = ptr_q[IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end

        if (hit) begin
          n_d = n_inc;
          if (chain_q) begin
            if (has_prev_q) begin
              mem_wr_en_o   = 1'b1;
              mem_wr_addr_o = prev_q;
              mem_wr_data_o = {clca_pkg::KIND_LINK, paddr_q};
            end else begin
              first_d = paddr_q;
            end
            has_prev_d = 1'b1;
            prev_d     = paddr_q;
          end
        end

        if (last_hit) begin
          if (chain_q) begin
            state_d = ST_FINAL;
          end else begin
            // enough free entries: rescan from the base and link them
            chain_d = 1'b1;
            n_d     = '0;
            ptr_d   = base_q;
            pend_d  = 1'b0;
          end
        end else if (!pend_q && (ptr_q >= N_P)) begin
          res_d.status = clca_pkg::STATUS_SHORT;
          state_d      = ST_DONE;
        end
      end

      ST_FINAL: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = prev_q;
        mem_wr_data_o = {clca_pkg::KIND_END, {IDX_W{1'b0}}};
        if (act_q == clca_pkg::ACT_ALLOC) begin
          res_d.first_cluster = clca_pkg::CLUSTER_W'(first_q);
        end
        state_d = ST_DONE;
      end

      ST_READ_CHK: begin
        if (rd_kind == clca_pkg::KIND_LINK) begin
          res_d.entry_kind   = clca_pkg::KIND_LINK;
          res_d.entry_target = clca_pkg::CLUSTER_W'(rd_tgt);
        end else if (rd_kind == clca_pkg::KIND_END) begin
          res_d.entry_kind = clca_pkg::KIND_END;
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (!res_stall_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      ptr_q      <= '0;
      report_q   <= 1'b0;
      pend_q     <= 1'b0;
      chain_q    <= 1'b0;
      has_prev_q <= 1'b0;
      n_q        <= '0;
      steps_q    <= '0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      report_q   <= report_d;
      pend_q     <= pend_d;
      chain_q    <= chain_d;
      has_prev_q <= has_prev_d;
      n_q        <= n_d;
      steps_q    <= steps_d;
      res_q      <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    cl_q    <= cl_d;
    cnt_q   <= cnt_d;
    need_q  <= need_d;
    base_q  <= base_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    paddr_q <= paddr_d;
    first_q <= first_d;
  end

  assign in_busy_o = (state_q != ST_IDLE);
  assign res_o     = res_q;

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_wr_en_o)
    else $error("table written while idle");

  a_rd_wr_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_wr_en_o && mem_rd_en_o) |-> (mem_wr_addr_o != mem_rd_addr_o))
    else $error("read and write hit the same entry");

  a_scan_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (n_q < need_q))
    else $error("scanner took more entries than needed");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK_RD) |-> (steps_q <= N_P))
    else $error("chain walk ran past the table size");
`endif

endmodule

// File: rtl/core/cluster_chain_allocator_top.sv
// ---------------------------------------------------------------------------
// cluster_chain_allocator_top
// cluster link table with format, allocate, extend, read and free actions
// ---------------------------------------------------------------------------
// One item is handled at a time; in_stall_o stays high until its result is
// in the output register. All work goes through one table read port and one
// write port, driven by one sequencer with a single free-entry scanner. After
// reset a clearing sweep over all NUM_CLUSTERS entries runs before the first
// item is taken. Format runs the same sweep and then reports. Allocate scans
// for count free entries and, when enough exist, scans again from the start
// to link them; a scan stops once enough free entries are found, and when
// too few are free the first scan reports short. Extend first walks the chain
// entry by entry to its tail, then, for a nonzero count, runs the same two
// scans starting above the tail. Read fetches one entry and free clears one.
// A result waits in the output register while the next item is taken.
// ---------------------------------------------------------------------------
module cluster_chain_allocator_top #(
  parameter int unsigned NUM_CLUSTERS = clca_pkg::NUM_CLUSTERS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [clca_pkg::ACTION_W-1:0]      action_i,
  input  logic [clca_pkg::CLUSTER_W-1:0]     cluster_i,
  input  logic [clca_pkg::COUNT_W-1:0]       count_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [clca_pkg::CLUSTER_W-1:0]     first_cluster_o,
  output logic [clca_pkg::KIND_W-1:0]        entry_kind_o,
  output logic [clca_pkg::CLUSTER_W-1:0]     entry_target_o,
  output logic [clca_pkg::STATUS_W-1:0]      status_o
);

  localparam int unsigned IDX_W = $clog2(NUM_CLUSTERS);
  localparam int unsigned ENT_W = IDX_W + clca_pkg::KIND_W;

  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [ENT_W-1:0]  mem_rd_data;
  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  logic [ENT_W-1:0]  mem_wr_data;

  logic              res_valid;
  logic              res_stall;
  clca_pkg::result_t res;

  logic              out_valid_q, out_valid_d;
  clca_pkg::result_t out_q;

  clca_table #(
    .NUM_CLUSTERS (NUM_CLUSTERS)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  clca_seq #(
    .NUM_CLUSTERS (NUM_CLUSTERS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_busy_o     (in_stall_o),
    .action_i      (action_i),
    .cluster_i     (cluster_i),
    .count_i       (count_i),
    .res_valid_o   (res_valid),
    .res_stall_i   (res_stall),
    .res_o         (res),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data)
  );

  // output register: holds a result until its transfer
  assign res_stall = out_valid_q && out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && !res_stall) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && !res_stall) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign first_cluster_o = out_q.first_cluster;
  assign entry_kind_o    = out_q.entry_kind;
  assign entry_target_o  = out_q.entry_target;
  assign status_o        = out_q.status;

endmodule

// File: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the cluster chain allocator
// ---------------------------------------------------------------------------
// Runs a short table of directed actions, then random action mixes under
// three idle patterns. Each result is checked against its typed row or a
// cycle-free table model, kept in step with each accepted input transfer.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM            = clca_pkg::NUM_CLUSTERS_DEF;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int TAIL_CYCLES    = 16;

  // action codes the block does not define
  localparam logic [clca_pkg::ACTION_W-1:0] ACT_RSVD_FIRST = 3'd5;
  localparam logic [clca_pkg::ACTION_W-1:0] ACT_RSVD_MID   = 3'd6;
  localparam logic [clca_pkg::ACTION_W-1:0] ACT_RSVD_LAST  = 3'd7;

  typedef struct {
    logic [clca_pkg::ACTION_W-1:0]  act;
    logic [clca_pkg::CLUSTER_W-1:0] cl;
    logic [clca_pkg::COUNT_W-1:0]   cnt;
    bit                             typed;
    logic [clca_pkg::CLUSTER_W-1:0] first;
    clca_pkg::kind_e                kind;
    logic [clca_pkg::CLUSTER_W-1:0] tgt;
    clca_pkg::status_e              st;
  } dir_row_t;

  logic                           clk_i;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  logic [clca_pkg::ACTION_W-1:0]  action_i    = '0;
  logic [clca_pkg::CLUSTER_W-1:0] cluster_i   = '0;
  logic [clca_pkg::COUNT_W-1:0]   count_i     = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [clca_pkg::CLUSTER_W-1:0] first_cluster_o;
  logic [clca_pkg::KIND_W-1:0]    entry_kind_o;
  logic [clca_pkg::CLUSTER_W-1:0] entry_target_o;
  logic [clca_pkg::STATUS_W-1:0]  status_o;

  cluster_chain_allocator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .cluster_i       (cluster_i),
    .count_i         (count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .first_cluster_o (first_cluster_o),
    .entry_kind_o    (entry_kind_o),
    .entry_target_o  (entry_target_o),
    .status_o        (status_o)
  );

  // model of the link table
  clca_pkg::kind_e                link_kind [NUM];
  logic [clca_pkg::CLUSTER_W-1:0] link_next [NUM];

  clca_pkg::result_t              pending_results [$];
  logic [clca_pkg::CLUSTER_W-1:0] chain_heads [$];
  clca_pkg::result_t              got_res;
  clca_pkg::result_t              exp_res;
  int                             errors         = 0;
  int                             send_idle_pct  = 0;
  int                             recv_stall_pct = 0;
  int                             holdoff_req    = 0;
  int                             holdoff_seen   = 0;
  int                             holdoff_left   = 0;

  dir_row_t dir_tbl [27] = '{
    '{clca_pkg::ACT_READ,   12'd0,    13'd0,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_READ,   12'd4095, 13'd0,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_ALLOC,  12'd0,    13'd0,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_ALLOC,  12'd0,    13'd1,    1'b1,
      12'd1, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_ALLOC,  12'd0,    13'd4096, 1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_SHORT},
    '{clca_pkg::ACT_READ,   12'd0,    13'd0,    1'b1,
      12'd0, clca_pkg::KIND_END,  12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_EXTEND, 12'd0,    13'd3,    1'b0,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_READ,   12'd0,    13'd0,    1'b0,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_READ,   12'd4,    13'd0,    1'b0,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_EXTEND, 12'd0,    13'd0,    1'b0,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_EXTEND, 12'd5,    13'd1,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_BROKEN},
    '{ACT_RSVD_FIRST,       12'd4095, 13'd4096, 1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{ACT_RSVD_MID,         12'd0,    13'd0,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{ACT_RSVD_LAST,        12'd1,    13'd1,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_FORMAT, 12'd0,    13'd0,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_ALLOC,  12'd0,    13'd4096, 1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_READ,   12'd4095, 13'd0,    1'b1,
      12'd0, clca_pkg::KIND_END,  12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_READ,   12'd4094, 13'd0,    1'b1,
      12'd0, clca_pkg::KIND_LINK, 12'd4095, clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_ALLOC,  12'd0,    13'd1,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_SHORT},
    '{clca_pkg::ACT_FREE,   12'd4095, 13'd0,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_EXTEND, 12'd4094, 13'd1,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_BROKEN},
    '{clca_pkg::ACT_EXTEND, 12'd0,    13'd1,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_BROKEN},
    '{clca_pkg::ACT_FORMAT, 12'd0,    13'd0,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_ALLOC,  12'd0,    13'd8,    1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_EXTEND, 12'd3,    13'd2,    1'b0,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK},
    '{clca_pkg::ACT_EXTEND, 12'd9,    13'd4096, 1'b1,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_SHORT},
    '{clca_pkg::ACT_READ,   12'd7,    13'd0,    1'b0,
      12'd0, clca_pkg::KIND_FREE, 12'd0,    clca_pkg::STATUS_OK}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (link_kind[i]) begin
      link_kind[i] = clca_pkg::KIND_FREE;
      link_next[i] = '0;
    end
  end

  // free entries at index >= lo, counting no further than need
  function automatic int count_free(int lo, int need);
    int n = 0;
    for (int i = lo; i < NUM && n < need; i++)
      if (link_kind[i] == clca_pkg::KIND_FREE) n++;
    return n;
  endfunction

  // takes need free entries at or above lo in ascending order and chains them
  function automatic int link_free(int lo, int need, bit has_prev, int prev);
    int taken = 0;
    int first = 0;
    for (int i = lo; i < NUM && taken < need; i++) begin
      if (link_kind[i] != clca_pkg::KIND_FREE) continue;
      if (has_prev) begin
        link_kind[prev] = clca_pkg::KIND_LINK;
        link_next[prev] = clca_pkg::CLUSTER_W'(i);
      end else begin
        first = i;
      end
      has_prev = 1'b1;
      prev     = i;
      taken++;
    end
    if (has_prev && taken > 0) begin
      link_kind[prev] = clca_pkg::KIND_END;
      link_next[prev] = '0;
    end
    return first;
  endfunction

  function automatic clca_pkg::result_t predict_result(
      logic [clca_pkg::ACTION_W-1:0] act,
      logic [clca_pkg::CLUSTER_W-1:0] cl,
      logic [clca_pkg::COUNT_W-1:0] cnt);
    clca_pkg::result_t res;
    int                need;
    int                c;
    int                steps;
    bit                found;
    bit                broken;
    res = '0;
    case (act)
      clca_pkg::ACT_FORMAT: begin
        foreach (link_kind[i]) begin
          link_kind[i] = clca_pkg::KIND_FREE;
          link_next[i] = '0;
        end
      end
      clca_pkg::ACT_ALLOC: begin
        need = (cnt < 1) ? 1 : int'(cnt);
        if (count_free(0, need) < need) res.status = clca_pkg::STATUS_SHORT;
        else res.first_cluster = clca_pkg::CLUSTER_W'(link_free(0, need, 1'b0, 0));
      end
      clca_pkg::ACT_EXTEND: begin
        c      = int'(cl);
        steps  = 0;
        found  = 1'b0;
        broken = 1'b0;
        while (!broken && !found) begin
          if (link_kind[c] == clca_pkg::KIND_END) begin
            found = 1'b1;
          end else if (link_kind[c] == clca_pkg::KIND_LINK && steps < NUM) begin
            c = int'(link_next[c]);
            steps++;
          end else begin
            broken = 1'b1;
          end
        end
        if (broken) begin
          res.status = clca_pkg::STATUS_BROKEN;
        end else if (cnt > 0) begin
          if (count_free(c + 1, int'(cnt)) < int'(cnt)) res.status = clca_pkg::STATUS_SHORT;
          else void'(link_free(c + 1, int'(cnt), 1'b1, c));
        end
      end
      clca_pkg::ACT_READ: begin
        res.entry_kind = link_kind[cl];
        if (link_kind[cl] == clca_pkg::KIND_LINK) res.entry_target = link_next[cl];
      end
      clca_pkg::ACT_FREE: begin
        link_kind[cl] = clca_pkg::KIND_FREE;
        link_next[cl] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // offers one item, waits for its transfer, then records what it should give
  task automatic transfer_item(input logic [clca_pkg::ACTION_W-1:0] act,
                               input logic [clca_pkg::CLUSTER_W-1:0] cl,
                               input logic [clca_pkg::COUNT_W-1:0] cnt,
                               input bit typed, input clca_pkg::result_t typed_res);
    clca_pkg::result_t pred;
    int                gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    cluster_i  <= cl;
    count_i    <= cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = predict_result(act, cl, cnt);
    if (act == clca_pkg::ACT_FORMAT) chain_heads.delete();
    else if (act == clca_pkg::ACT_ALLOC && pred.status == clca_pkg::STATUS_OK)
      chain_heads.push_back(pred.first_cluster);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // mostly chains built and grown from known heads, with frees as noise
  task automatic run_random(input int n);
    int                             r;
    int                             p;
    logic [clca_pkg::ACTION_W-1:0]  act;
    logic [clca_pkg::CLUSTER_W-1:0] cl;
    logic [clca_pkg::COUNT_W-1:0]   cnt;
    repeat (n) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 99);
      if (p < 70) cnt = clca_pkg::COUNT_W'($urandom_range(0, 8));
      else if (p < 95) cnt = clca_pkg::COUNT_W'($urandom_range(9, 200));
      else cnt = clca_pkg::COUNT_W'($urandom_range(0, NUM));
      p = $urandom_range(0, 99);
      if (chain_heads.size() != 0 && p < 60)
        cl = chain_heads[$urandom_range(0, chain_heads.size() - 1)]
             + clca_pkg::CLUSTER_W'($urandom_range(0, 3));
      else if (p < 85) cl = clca_pkg::CLUSTER_W'($urandom_range(0, 300));
      else cl = clca_pkg::CLUSTER_W'($urandom);
      if (r < 4) act = clca_pkg::ACT_FORMAT;
      else if (r < 40) act = clca_pkg::ACT_ALLOC;
      else if (r < 65) act = clca_pkg::ACT_EXTEND;
      else if (r < 85) act = clca_pkg::ACT_READ;
      else if (r < 95) act = clca_pkg::ACT_FREE;
      else act = clca_pkg::ACTION_W'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
      transfer_item(act, cl, cnt, 1'b0, '0);
    end
  endtask

  // result side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      got_res.first_cluster = first_cluster_o;
      got_res.entry_kind    = clca_pkg::kind_e'(entry_kind_o);
      got_res.entry_target  = entry_target_o;
      got_res.status        = clca_pkg::status_e'(status_o);
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: first %0d kind %0d target %0d status %0d",
                 $time, got_res.first_cluster, got_res.entry_kind,
                 got_res.entry_target, got_res.status);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got_res !== exp_res) begin
          $display("%0t mismatch: expected first %0d kind %0d target %0d status %0d",
                   $time, exp_res.first_cluster, exp_res.entry_kind,
                   exp_res.entry_target, exp_res.status);
          $display("%0t            actual first %0d kind %0d target %0d status %0d",
                   $time, got_res.first_cluster, got_res.entry_kind,
                   got_res.entry_target, got_res.status);
          errors++;
        end
      end
    end
    if (holdoff_seen != holdoff_req) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // ends the run when no transfer happens on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct  = 17;
    recv_stall_pct = 70;
    foreach (dir_tbl[i])
      transfer_item(dir_tbl[i].act, dir_tbl[i].cl, dir_tbl[i].cnt, dir_tbl[i].typed,
                    clca_pkg::result_t'{dir_tbl[i].first, dir_tbl[i].kind,
                                        dir_tbl[i].tgt, dir_tbl[i].st});
    run_random(37);

    // sender pauses until the block has handed back everything
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    send_idle_pct  = 70;
    recv_stall_pct = 17;
    run_random(37);

    // long receiver hold-off while reads keep coming, so the input stalls
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_req++;
    repeat (8)
      transfer_item(clca_pkg::ACT_READ, clca_pkg::CLUSTER_W'($urandom_range(0, 300)), '0,
                    1'b0, '0);
    run_random(31);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
